>>> rtl/core/timer_table_with_reload_defines.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Shared concurrent assertion forms for the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef TIMER_TABLE_WITH_RELOAD_DEFINES_SVH
`define TIMER_TABLE_WITH_RELOAD_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TTR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer table check failed");

// Next-cycle implication, disabled while reset is high.
`define TTR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer table check failed");

`endif

>>> rtl/core/ttr_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Widths, codes and record types shared by the timer table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttr_pkg;

   localparam int TIME_W      = 48;
   localparam int ID_W        = 8;
   localparam int DLY_W       = 16;
   localparam int COOKIE_W    = 32;
   localparam int KIND_W      = 3;
   localparam int OP_W        = 2;
   localparam int MAX_RESULTS = 16;
   localparam int FIRE_W      = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH = 2;

   // Request opcodes; the fourth code carries no operation.
   typedef enum logic [OP_W-1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_DEL  = 2'd2
   } op_type;

   // Result kinds.
   typedef enum logic [KIND_W-1:0] {
      EV_EXPIRED    = 3'd0,
      EV_ADDED      = 3'd1,
      EV_MODIFIED   = 3'd2,
      EV_DELETED    = 3'd3,
      EV_NOT_FOUND  = 3'd4,
      EV_TABLE_FULL = 3'd5
   } event_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      op_type                kind;
      logic [ID_W-1:0]       id;
      logic [DLY_W:0]        delay_sum;
      logic [DLY_W-1:0]      reload;
      logic [COOKIE_W-1:0]   cookie;
   } cmd_type;

   // One timer record as held in the slot memory.
   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [TIME_W-1:0]     expiry;
      logic [DLY_W-1:0]      reload;
      logic [COOKIE_W-1:0]   cookie;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

`default_nettype wire

>>> rtl/core/ttr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/ttr_front.sv
// ----------------------------------------------------------------------------
// Timer table front end
// Decodes request words, masks the delays and pre-adds the start and expire delays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_front import ttr_pkg::*; #(
   parameter int DELAY_BITS = 16
) (
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic [ID_W-1:0]       req_timer_id,
   input  wire logic [DLY_W-1:0]      req_start_delay,
   input  wire logic [DLY_W-1:0]      req_expire_delay,
   input  wire logic [DLY_W-1:0]      req_reload_period,
   input  wire logic [COOKIE_W-1:0]   req_cookie,
   output      logic                  cmd_valid,
   input  wire logic                  cmd_stall,
   output      cmd_type               cmd
);

   localparam logic [DLY_W-1:0] DELAY_MASK = (DELAY_BITS >= DLY_W) ? {DLY_W{1'b1}} :
                                             DLY_W'((33'd1 << DELAY_BITS) - 33'd1);

   logic [DLY_W-1:0] start_m;
   logic [DLY_W-1:0] expire_m;
   logic             known_op;

   // Only the low delay bits take part in the timing.
   assign start_m  = req_start_delay & DELAY_MASK;
   assign expire_m = req_expire_delay & DELAY_MASK;

   // Build the command word for the queue and classify the opcode; the
   // unused code is taken and dropped.
   always_comb begin
      cmd.kind      = OP_TICK;
      cmd.id        = req_timer_id;
      cmd.delay_sum = {1'b0, start_m} + {1'b0, expire_m};
      cmd.reload    = req_reload_period & DELAY_MASK;
      cmd.cookie    = req_cookie;
      known_op      = 1'b1;
      unique case (req_opcode)
         OP_TICK: cmd.kind = OP_TICK;
         OP_SET:  cmd.kind = OP_SET;
         OP_DEL:  cmd.kind = OP_DEL;
         default: known_op = 1'b0;
      endcase
   end

   assign cmd_valid = req_valid && known_op;
   assign req_stall = cmd_stall;

endmodule

`default_nettype wire

>>> rtl/core/ttr_fifo.sv
// ----------------------------------------------------------------------------
// Timer table command queue
// Short queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttr_fifo import ttr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output      logic      push_stall,
   input  wire cmd_type   push_data,
   output      logic      pop_valid,
   input  wire logic      pop_stall,
   output      cmd_type   pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ttr_engine.sv
// ----------------------------------------------------------------------------
// Timer table engine
// Scans the slot memory one slot per cycle and carries out each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "timer_table_with_reload_defines.svh"

module ttr_engine import ttr_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output      logic                  cmd_stall,
   input  wire cmd_type               cmd,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [KIND_W-1:0]     rsp_event_kind,
   output      logic [ID_W-1:0]       rsp_event_id,
   output      logic [COOKIE_W-1:0]   rsp_event_cookie,
   output      logic                  rsp_was_reloaded,
   output      logic                  rsp_last_of_run
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(SLOTS);
   localparam logic [FIRE_W-1:0] FIRE_LAST = FIRE_W'(MAX_RESULTS - 1);

   // Sequencer and table state.
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   slot_type             best_slot_ff, best_slot_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]     elig_cnt_ff, elig_cnt_in;
   logic [FIRE_W-1:0]    fire_n_ff, fire_n_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     fired_ff, fired_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [COOKIE_W-1:0]  rsp_cookie_ff, rsp_cookie_in;
   logic                 rsp_reload_ff, rsp_reload_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Slot memory ports.
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   slot_type             ram_wslot;
   logic [IDX_W-1:0]     ram_raddr;
   logic [SLOT_W-1:0]    ram_rdata;
   slot_type             rd_slot;

   // Sequencer outputs.
   logic                 take_cmd;
   logic                 out_free;
   logic                 decide_go;
   logic                 emit;
   event_type            emit_kind;
   logic                 emit_last;
   logic                 is_tick;
   logic                 is_set;
   logic                 is_del;
   logic                 chk_on;
   logic [IDX_W-1:0]     chk_idx;

   ttr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wslot),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_slot = slot_type'(ram_rdata);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == SCAN_END) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = (is_tick && found_ff && !emit_last) ? ST_SCAN : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      is_tick   = (cmd_ff.kind == OP_TICK);
      is_set    = (cmd_ff.kind == OP_SET);
      is_del    = (cmd_ff.kind == OP_DEL);
      cmd_stall = (state_ff != ST_IDLE);
      take_cmd  = (state_ff == ST_IDLE) && cmd_valid;
      out_free  = !rsp_valid_ff || !rsp_stall;
      decide_go = (state_ff == ST_DECIDE) && out_free;
      emit      = decide_go && (!is_tick || found_ff);

      // Read one slot per scan cycle; check it in the next cycle.
      ram_raddr = (cnt_ff < SCAN_END) ? cnt_ff[IDX_W-1:0] : '0;
      chk_on    = (state_ff == ST_SCAN) && (cnt_ff != '0);
      chk_idx   = IDX_W'(cnt_ff - CNT_W'(1));

      // Result kind and end-of-run flag.
      emit_kind = EV_EXPIRED;
      emit_last = 1'b1;
      unique case (cmd_ff.kind)
         OP_TICK: begin
            emit_kind = EV_EXPIRED;
            emit_last = (elig_cnt_ff == CNT_W'(1)) || (fire_n_ff == FIRE_LAST);
         end
         OP_SET: begin
            if (found_ff) begin
               emit_kind = EV_MODIFIED;
            end else if (free_found_ff) begin
               emit_kind = EV_ADDED;
            end else begin
               emit_kind = EV_TABLE_FULL;
            end
         end
         OP_DEL: emit_kind = found_ff ? EV_DELETED : EV_NOT_FOUND;
         default: emit_kind = EV_EXPIRED;
      endcase

      // Slot write: reload a fired timer, or store an added or modified one.
      ram_we    = decide_go && ((is_tick && found_ff && (best_slot_ff.reload != '0)) ||
                                (is_set && (found_ff || free_found_ff)));
      ram_waddr = (is_set && !found_ff) ? free_idx_ff : best_idx_ff;
      if (is_tick) begin
         ram_wslot        = best_slot_ff;
         ram_wslot.expiry = best_slot_ff.expiry + TIME_W'(best_slot_ff.reload);
      end else begin
         ram_wslot.id     = cmd_ff.id;
         ram_wslot.expiry = now_ff + TIME_W'(cmd_ff.delay_sum);
         ram_wslot.reload = cmd_ff.reload;
         ram_wslot.cookie = cmd_ff.cookie;
      end
   end

   // Datapath next values.
   always_comb begin
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_slot_in  = best_slot_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      elig_cnt_in   = elig_cnt_ff;
      fire_n_in     = fire_n_ff;
      valid_in      = valid_ff;
      fired_in      = fired_ff;

      // A new command clears the scan; a tick advances time first.
      if (take_cmd) begin
         cmd_in        = cmd;
         cnt_in        = '0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         elig_cnt_in   = '0;
         if (cmd.kind == OP_TICK) begin
            now_in    = now_ff + TIME_W'(1);
            fired_in  = '0;
            fire_n_in = '0;
         end
      end

      // Scan: keep the earliest due slot, or the id match and first free slot.
      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (chk_on) begin
         if (is_tick) begin
            if (valid_ff[chk_idx] && !fired_ff[chk_idx] && (rd_slot.expiry <= now_ff)) begin
               elig_cnt_in = elig_cnt_ff + CNT_W'(1);
               if (!found_ff || (rd_slot.expiry < best_slot_ff.expiry)) begin
                  found_in     = 1'b1;
                  best_idx_in  = chk_idx;
                  best_slot_in = rd_slot;
               end
            end
         end else begin
            if (valid_ff[chk_idx] && (rd_slot.id == cmd_ff.id) && !found_ff) begin
               found_in    = 1'b1;
               best_idx_in = chk_idx;
            end
            if (!valid_ff[chk_idx] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx;
            end
         end
      end

      // Decide: update the slot flags and, after a tick expiry, prepare another pass.
      if (decide_go) begin
         if (is_tick && found_ff) begin
            fired_in[best_idx_ff] = 1'b1;
            if (best_slot_ff.reload == '0) begin
               valid_in[best_idx_ff] = 1'b0;
            end
            fire_n_in   = fire_n_ff + FIRE_W'(1);
            cnt_in      = '0;
            found_in    = 1'b0;
            elig_cnt_in = '0;
         end
         if (is_set && !found_ff && free_found_ff) begin
            valid_in[free_idx_ff] = 1'b1;
         end
         if (is_del && found_ff) begin
            valid_in[best_idx_ff] = 1'b0;
         end
      end
   end

   // Result register next values.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cookie_in = rsp_cookie_ff;
      rsp_reload_in = rsp_reload_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = emit_kind;
         rsp_id_in     = is_tick ? best_slot_ff.id : cmd_ff.id;
         rsp_cookie_in = is_tick ? best_slot_ff.cookie : '0;
         rsp_reload_in = is_tick && (best_slot_ff.reload != '0);
         rsp_last_in   = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         elig_cnt_ff   <= '0;
         fire_n_ff     <= '0;
         valid_ff      <= '0;
         fired_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         cnt_ff        <= cnt_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         elig_cnt_ff   <= elig_cnt_in;
         fire_n_ff     <= fire_n_in;
         valid_ff      <= valid_in;
         fired_ff      <= fired_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      best_idx_ff   <= best_idx_in;
      best_slot_ff  <= best_slot_in;
      free_idx_ff   <= free_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cookie_ff <= rsp_cookie_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_id     = rsp_id_ff;
   assign rsp_event_cookie = rsp_cookie_ff;
   assign rsp_was_reloaded = rsp_reload_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   // A chosen due timer was counted as due during its scan.
   `TTR_ASSERT_IMP(a_found_counted, clock, reset, (state_ff == ST_DECIDE) && is_tick && found_ff, elig_cnt_ff != '0)
   // The run ends by the last allowed expiry of one tick.
   `TTR_ASSERT_IMP(a_fire_bound, clock, reset, emit && is_tick && (fire_n_ff == FIRE_LAST), emit_last)
   // A full scan always hands over to the decision step.
   `TTR_ASSERT_NXT(a_scan_exit, clock, reset, (state_ff == ST_SCAN) && (cnt_ff == SCAN_END), state_ff == ST_DECIDE)
   // A one-shot timer is gone after it fires.
   `TTR_ASSERT_NXT(a_oneshot_gone, clock, reset, decide_go && is_tick && found_ff && (best_slot_ff.reload == '0), !valid_ff[$past(best_idx_ff)])

endmodule

`default_nettype wire

>>> rtl/core/timer_table_with_reload.sv
// A table of SLOTS software timers keyed by 8-bit id. Add-or-modify, delete and
// tick words enter through a two-word command queue, and the engine carries each
// out by scanning the slot memory (one write port, one registered read port) one
// slot per cycle. An add or delete gives one result word. A tick advances the
// 48-bit time in its accept cycle and then runs one scan per expiring timer (at
// least one scan, at most 16). A stalled result holds the engine in its decision
// step until the word is taken. Results wait in an output register while the
// queue takes new request words until it is full; the table starts empty after
// reset with no clearing pass.
// ----------------------------------------------------------------------------
// Timer table with reload
// Top level: front end, command queue and scanning engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timer_table_with_reload import ttr_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int DELAY_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic [ID_W-1:0]       req_timer_id,
   input  wire logic [DLY_W-1:0]      req_start_delay,
   input  wire logic [DLY_W-1:0]      req_expire_delay,
   input  wire logic [DLY_W-1:0]      req_reload_period,
   input  wire logic [COOKIE_W-1:0]   req_cookie,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [KIND_W-1:0]     rsp_event_kind,
   output      logic [ID_W-1:0]       rsp_event_id,
   output      logic [COOKIE_W-1:0]   rsp_event_cookie,
   output      logic                  rsp_was_reloaded,
   output      logic                  rsp_last_of_run
);

   logic      front_valid;
   logic      front_stall;
   cmd_type   front_cmd;
   logic      queue_valid;
   logic      queue_stall;
   cmd_type   queue_cmd;

   // Request decode.
   ttr_front #(
      .DELAY_BITS (DELAY_BITS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_timer_id      (req_timer_id),
      .req_start_delay   (req_start_delay),
      .req_expire_delay  (req_expire_delay),
      .req_reload_period (req_reload_period),
      .req_cookie        (req_cookie),
      .cmd_valid         (front_valid),
      .cmd_stall         (front_stall),
      .cmd               (front_cmd)
   );

   // Command queue.
   ttr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_stall (front_stall),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_stall  (queue_stall),
      .pop_data   (queue_cmd)
   );

   // Table engine.
   ttr_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_valid),
      .cmd_stall        (queue_stall),
      .cmd              (queue_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_id     (rsp_event_id),
      .rsp_event_cookie (rsp_event_cookie),
      .rsp_was_reloaded (rsp_was_reloaded),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire
